FILE: rtl/stq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stq_pkg - shared types and constants for the sorted timer event queue
// Sizes, transaction payloads, cell entry/op structs, codes and FSM states.
// ----------------------------------------------------------------------------
package stq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int TAG_BITS    = 8;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_ADD  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic        mode;
		logic [31:0] timeout;
		logic [7:0]  event_tag;
	} item_t;

	typedef struct packed {
		logic        fired;
		logic [7:0]  fired_tag;
		logic [1:0]  status;
		logic [4:0]  pending;
		logic [31:0] next_wait;
	} result_t;

	typedef struct packed {
		logic [63:0]         deadline;
		logic [TAG_BITS-1:0] tag;
	} entry_t;

	typedef struct packed {
		logic   insert;
		logic   pop;
		entry_t entry;
	} cell_op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PREP,
		S_APPLY,
		S_REPORT
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/stq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stq_cell - one slot of the sorted deadline chain
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbor's; on pop it takes its right neighbor's.
// ----------------------------------------------------------------------------
module stq_cell import stq_pkg::*; (
	input  wire logic     clk,
	input  wire cell_op_t op,
	input  wire logic     occ,
	input  wire logic     prev_le,
	input  wire entry_t   left,
	input  wire entry_t   right,
	output entry_t        entry,
	output logic          le
);

	entry_t entry_q;

	assign entry = entry_q;
	// occupied and due no later than the new deadline: stays ahead of it
	assign le    = occ && (entry_q.deadline <= op.entry.deadline);

	always_ff @(posedge clk) begin
		if (op.insert) begin
			if (!le) begin
				entry_q <= prev_le ? op.entry : left;
			end
		end else if (op.pop) begin
			entry_q <= right;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/sorted_timer_event_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_timer_event_queue - deadline-ordered timer queue on one time base
// Tick counter plus a chain of cells kept sorted by deadline; adds insert,
// ticks advance time and pop at most one due timer.
// ----------------------------------------------------------------------------
//  channel  | signals                      | transfer
//  ---------+------------------------------+-----------------------------------
//  item     | start, busy, item            | start & !busy at a rising edge
//  result   | result_valid, result         | one-cycle strobe, cannot stall
//
// Each transaction steps through accept, deadline/time update, chain
// update and next-wait compute; the result strobe comes in the cycle after,
// when busy is already low again. The FSM sequences these steps.
// Reset clears time, entry count and FSM; cell contents are not reset.
// The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue import stq_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	input  wire item_t item,
	output logic       result_valid,
	output result_t    result
);

	state_t           state_q, state_d;
	logic [63:0]      time_q;
	logic [63:0]      dl_q;
	logic [CNT_W-1:0] count_q;
	item_t            item_q;
	result_t          res_q;
	logic             result_valid_q;

	cell_op_t op;
	entry_t   cell_entry [QUEUE_DEPTH];
	logic     cell_le    [QUEUE_DEPTH];

	logic        accept;
	logic        full;
	logic        head_due;
	logic        in_prep, in_apply, in_report;
	logic [63:0] diff;
	logic [31:0] wait_c;

	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_due = (count_q != '0) && (cell_entry[0].deadline <= time_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (accept) state_d = S_PREP;
			S_PREP:   state_d = S_APPLY;
			S_APPLY:  state_d = S_REPORT;
			S_REPORT: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs of the FSM
	always_comb begin
		busy      = 1'b1;
		in_prep   = 1'b0;
		in_apply  = 1'b0;
		in_report = 1'b0;
		case (state_q)
			S_IDLE:   busy = 1'b0;
			S_PREP:   in_prep = 1'b1;
			S_APPLY:  in_apply = 1'b1;
			S_REPORT: in_report = 1'b1;
			default:  busy = 1'b0;
		endcase
	end

	always_comb begin
		op.insert         = in_apply && (item_q.mode == MODE_ADD) && !full;
		op.pop            = in_apply && (item_q.mode == MODE_TICK) && head_due;
		op.entry.deadline = dl_q;
		op.entry.tag      = TAG_BITS'(item_q.event_tag);
	end

	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		entry_t left_w, right_w;
		logic   prev_le_w;
		if (k == 0) begin : g_first
			assign left_w    = op.entry;
			assign prev_le_w = 1'b1;
		end else begin : g_mid
			assign left_w    = cell_entry[k-1];
			assign prev_le_w = cell_le[k-1];
		end
		if (k == QUEUE_DEPTH - 1) begin : g_last
			assign right_w = cell_entry[k];
		end else begin : g_inner
			assign right_w = cell_entry[k+1];
		end
		stq_cell u_cell (
			.clk     (clk),
			.op      (op),
			.occ     (CNT_W'(k) < count_q),
			.prev_le (prev_le_w),
			.left    (left_w),
			.right   (right_w),
			.entry   (cell_entry[k]),
			.le      (cell_le[k])
		);
	end

	// ticks to the head deadline, saturated to 32 bits
	assign diff = cell_entry[0].deadline - time_q;
	always_comb begin
		if (!head_due && (count_q != '0)) begin
			wait_c = (diff[63:32] != '0) ? '1 : diff[31:0];
		end else begin
			wait_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			time_q         <= '0;
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= in_report;
			if (in_prep && (item_q.mode == MODE_TICK)) begin
				time_q <= time_q + 64'd1;
			end
			if (op.insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (op.pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (in_prep) begin
			dl_q <= time_q + {32'd0, item_q.timeout};
		end
		if (in_apply) begin
			res_q.fired     <= op.pop;
			res_q.fired_tag <= op.pop ? 8'(cell_entry[0].tag) : 8'd0;
			if (item_q.mode == MODE_ADD) begin
				res_q.status <= full ? ST_FULL : ST_OK;
			end else begin
				res_q.status <= (count_q == '0) ? ST_EMPTY : ST_OK;
			end
		end
		if (in_report) begin
			res_q.pending   <= 5'(count_q);
			res_q.next_wait <= wait_c;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = res_q;

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy) else $error("result strobe while busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH)) else $error("entry count past depth");

	a_fire_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.fired |-> result.status == ST_OK)
		else $error("fired with non-ok status");

	a_empty_wait: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.pending == 5'd0) |-> result.next_wait == 32'd0)
		else $error("nonzero wait with empty queue");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted transaction not busy");

endmodule
`default_nettype wire
